// ----- rtl/pef_pkg.sv -----
// Shared types and constants for the prefix expression evaluator.
// No dependencies; every other file in rtl refers to it by scoped names.
package pef_pkg;

   // ASCII characters that the evaluator recognises
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   // operator codes held in the stack
   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_POW = 3'd4;

   // classes of an incoming symbol
   localparam logic [1:0] KIND_NUM = 2'd0;
   localparam logic [1:0] KIND_OPR = 2'd1;
   localparam logic [1:0] KIND_BAD = 2'd2;

   // result status codes
   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_BADSYM = 3'd1;
   localparam logic [2:0] ST_DIVZ   = 3'd2;
   localparam logic [2:0] ST_OVF    = 3'd3;
   localparam logic [2:0] ST_MALF   = 3'd4;
   localparam logic [2:0] ST_NEGEXP = 3'd5;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] code;
      logic [3:0] digit;
      logic       last;
   } item_type;

endpackage

// ----- rtl/pef_front.sv -----
// Front end: decodes each incoming character into a classified item.
// Depends on pef_pkg.
module pef_front (
   input  logic              req_valid,
   input  logic [7:0]        req_symbol,
   input  logic              req_last_symbol,
   input  logic              q_full,
   output logic              req_stall,
   output logic              q_push,
   output pef_pkg::item_type q_item
);

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_item       = '0;
      q_item.last  = req_last_symbol;
      q_item.digit = req_symbol[3:0];
      q_item.kind  = pef_pkg::KIND_OPR;
      priority if (req_symbol >= pef_pkg::CH_ZERO && req_symbol <= pef_pkg::CH_NINE) begin
         q_item.kind = pef_pkg::KIND_NUM;
      end else if (req_symbol == pef_pkg::CH_PLUS) begin
         q_item.code = pef_pkg::OP_ADD;
      end else if (req_symbol == pef_pkg::CH_MINUS) begin
         q_item.code = pef_pkg::OP_SUB;
      end else if (req_symbol == pef_pkg::CH_STAR) begin
         q_item.code = pef_pkg::OP_MUL;
      end else if (req_symbol == pef_pkg::CH_SLASH) begin
         q_item.code = pef_pkg::OP_DIV;
      end else if (req_symbol == pef_pkg::CH_DOLLAR) begin
         q_item.code = pef_pkg::OP_POW;
      end else begin
         q_item.kind = pef_pkg::KIND_BAD;
      end
   end

endmodule

// ----- rtl/pef_queue.sv -----
// Short queue of classified items between front and back end.
// Depends on pef_pkg.
module pef_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pef_pkg::item_type push_item,
   output logic              full,
   output logic              pop_valid,
   input  logic              pop,
   output pef_pkg::item_type pop_item
);

   localparam int PW = $clog2(pef_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(pef_pkg::QUEUE_DEPTH + 1);

   pef_pkg::item_type slot_ff [pef_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign full      = (cnt_ff == CW'(pef_pkg::QUEUE_DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_item  = slot_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_in  = do_push ? PW'(wr_ff + PW'(1)) : wr_ff;
      rd_in  = do_pop  ? PW'(rd_ff + PW'(1)) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) cnt_in = cnt_ff + CW'(1);
      if (do_pop && !do_push) cnt_in = cnt_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) slot_ff[wr_ff] <= push_item;
   end

endmodule

// ----- rtl/pef_alu.sv -----
// Iterative arithmetic unit: add, subtract, shift-add multiply,
// restoring divide and square-and-multiply power. Depends on pef_pkg.
module pef_alu #(
   parameter int W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [2:0]   op,
   input  logic [W-1:0] opa,
   input  logic [W-1:0] opb,
   output logic         done,
   output logic [W-1:0] result,
   output logic [2:0]   status
);

   localparam int CW = $clog2(W + 1);

   localparam logic [2:0] A_IDLE = 3'd0;
   localparam logic [2:0] A_MUL  = 3'd1;
   localparam logic [2:0] A_DIV  = 3'd2;
   localparam logic [2:0] A_PCHK = 3'd3;
   localparam logic [2:0] A_PR   = 3'd4;
   localparam logic [2:0] A_PB   = 3'd5;

   logic [2:0]   st_ff, st_in;
   logic [W-1:0] mx_ff, mx_in, my_ff, my_in, mp_ff, mp_in;
   logic [W-1:0] pr_ff, pr_in, pb_ff, pb_in, pe_ff, pe_in;
   logic [W:0]   rem_ff, rem_in;
   logic [W-1:0] quo_ff, quo_in, ub_ff, ub_in;
   logic         neg_ff, neg_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0] res_ff, res_in;
   logic [2:0]   stat_ff, stat_in;
   logic         done_ff, done_in;

   logic [W-1:0] mstep_p;
   logic [W:0]   rsh, rsub;
   logic         ge;
   logic [W-1:0] qfin;

   assign done   = done_ff;
   assign result = res_ff;
   assign status = stat_ff;

   assign mstep_p = mp_ff + (my_ff[0] ? mx_ff : '0);
   assign rsh     = {rem_ff[W-1:0], quo_ff[W-1]};
   assign ge      = (rsh >= {1'b0, ub_ff});
   assign rsub    = rsh - {1'b0, ub_ff};
   assign qfin    = {quo_ff[W-2:0], ge};

   always_comb begin
      st_in   = st_ff;
      mx_in   = mx_ff;
      my_in   = my_ff;
      mp_in   = mp_ff;
      pr_in   = pr_ff;
      pb_in   = pb_ff;
      pe_in   = pe_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      ub_in   = ub_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      res_in  = res_ff;
      stat_in = stat_ff;
      done_in = 1'b0;
      unique case (st_ff)
         A_IDLE: begin
            if (start) begin
               stat_in = pef_pkg::ST_OK;
               unique case (op)
                  pef_pkg::OP_ADD: begin
                     res_in  = opa + opb;
                     done_in = 1'b1;
                  end
                  pef_pkg::OP_SUB: begin
                     res_in  = opa - opb;
                     done_in = 1'b1;
                  end
                  pef_pkg::OP_MUL: begin
                     mx_in = opa;
                     my_in = opb;
                     mp_in = '0;
                     st_in = A_MUL;
                  end
                  pef_pkg::OP_DIV: begin
                     if (opb == '0) begin
                        stat_in = pef_pkg::ST_DIVZ;
                        done_in = 1'b1;
                     end else begin
                        neg_in = opa[W-1] ^ opb[W-1];
                        quo_in = opa[W-1] ? W'(-opa) : opa;
                        ub_in  = opb[W-1] ? W'(-opb) : opb;
                        rem_in = '0;
                        cnt_in = '0;
                        st_in  = A_DIV;
                     end
                  end
                  default: begin
                     if (opb[W-1]) begin
                        stat_in = pef_pkg::ST_NEGEXP;
                        done_in = 1'b1;
                     end else begin
                        pr_in = W'(1);
                        pb_in = opa;
                        pe_in = opb;
                        st_in = A_PCHK;
                     end
                  end
               endcase
            end
         end
         A_MUL: begin
            if (my_ff == '0) begin
               res_in  = mp_ff;
               done_in = 1'b1;
               st_in   = A_IDLE;
            end else begin
               mp_in = mstep_p;
               mx_in = mx_ff << 1;
               my_in = my_ff >> 1;
            end
         end
         A_DIV: begin
            rem_in = ge ? rsub : rsh;
            quo_in = qfin;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(W - 1)) begin
               res_in  = neg_ff ? W'(-qfin) : qfin;
               done_in = 1'b1;
               st_in   = A_IDLE;
            end
         end
         A_PCHK: begin
            mp_in = '0;
            if (pe_ff == '0) begin
               res_in  = pr_ff;
               done_in = 1'b1;
               st_in   = A_IDLE;
            end else if (pe_ff[0]) begin
               mx_in = pr_ff;
               my_in = pb_ff;
               st_in = A_PR;
            end else begin
               mx_in = pb_ff;
               my_in = pb_ff;
               st_in = A_PB;
            end
         end
         A_PR: begin
            if (my_ff == '0) begin
               pr_in = mp_ff;
               mx_in = pb_ff;
               my_in = pb_ff;
               mp_in = '0;
               st_in = A_PB;
            end else begin
               mp_in = mstep_p;
               mx_in = mx_ff << 1;
               my_in = my_ff >> 1;
            end
         end
         A_PB: begin
            if (my_ff == '0) begin
               pb_in = mp_ff;
               pe_in = pe_ff >> 1;
               st_in = A_PCHK;
            end else begin
               mp_in = mstep_p;
               mx_in = mx_ff << 1;
               my_in = my_ff >> 1;
            end
         end
         default: st_in = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= A_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      mp_ff   <= mp_in;
      pr_ff   <= pr_in;
      pb_ff   <= pb_in;
      pe_ff   <= pe_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      ub_ff   <= ub_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      res_ff  <= res_in;
      stat_ff <= stat_in;
   end

endmodule

// ----- rtl/pef_back.sv -----
// Back end: tagged evaluation stack in a memory, reduction sequencer and
// result register. Depends on pef_pkg and pef_alu.
module pef_back #(
   parameter int D = 128,
   parameter int W = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  pef_pkg::item_type q_item,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic signed [31:0] rsp_value,
   output logic [2:0]        rsp_status
);

   localparam int AW  = $clog2(D);
   localparam int SPW = $clog2(D + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CHK  = 3'd1;
   localparam logic [2:0] S_R1   = 3'd2;
   localparam logic [2:0] S_R2   = 3'd3;
   localparam logic [2:0] S_R3   = 3'd4;
   localparam logic [2:0] S_ALU  = 3'd5;
   localparam logic [2:0] S_FIN  = 3'd6;
   localparam logic [2:0] S_FRD  = 3'd7;

   logic [W:0] mem [D];
   logic [W:0] rd_data_ff;

   logic [2:0]     st_ff, st_in;
   logic [SPW-1:0] sp_ff, sp_in;
   logic [2:0]     err_ff, err_in;
   logic           last_ff, last_in;
   logic [W-1:0]   a_ff, a_in, b_ff, b_in;
   logic           ov_ff, ov_in;
   logic signed [31:0] ovalue_ff, ovalue_in;
   logic [2:0]     ostat_ff, ostat_in;

   logic [SPW-1:0] sp_m1, sp_m2, sp_m3;
   logic [AW-1:0]  rd_addr, wr_addr;
   logic [W:0]     wr_data;
   logic           wr_en;
   logic           alu_start, alu_done;
   logic [W-1:0]   alu_res;
   logic [2:0]     alu_stat;
   logic [2:0]     rest_state;

   assign sp_m1 = sp_ff - SPW'(1);
   assign sp_m2 = sp_ff - SPW'(2);
   assign sp_m3 = sp_ff - SPW'(3);

   assign rsp_valid  = ov_ff;
   assign rsp_value  = ovalue_ff;
   assign rsp_status = ostat_ff;

   assign q_pop      = (st_ff == S_IDLE) && q_valid;
   assign rest_state = last_ff ? S_FIN : S_IDLE;

   pef_alu #(.W(W)) u_alu (
      .clock  (clock),
      .reset  (reset),
      .start  (alu_start),
      .op     (rd_data_ff[2:0]),
      .opa    (a_ff),
      .opb    (b_ff),
      .done   (alu_done),
      .result (alu_res),
      .status (alu_stat)
   );

   always_comb begin
      unique case (st_ff)
         S_CHK:        rd_addr = sp_m1[AW-1:0];
         S_R1:         rd_addr = sp_m2[AW-1:0];
         S_R2:         rd_addr = sp_m3[AW-1:0];
         S_FIN, S_FRD: rd_addr = '0;
         default:      rd_addr = sp_m1[AW-1:0];
      endcase
   end

   always_comb begin
      st_in     = st_ff;
      sp_in     = sp_ff;
      err_in    = err_ff;
      last_in   = last_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      ov_in     = ov_ff && rsp_stall;
      ovalue_in = ovalue_ff;
      ostat_in  = ostat_ff;
      wr_en     = 1'b0;
      wr_addr   = sp_ff[AW-1:0];
      wr_data   = '0;
      alu_start = 1'b0;
      unique case (st_ff)
         S_IDLE: begin
            if (q_valid) begin
               last_in = q_item.last;
               st_in   = q_item.last ? S_FIN : S_IDLE;
               if (err_ff != pef_pkg::ST_OK) begin
                  // drop symbols after an error
               end else if (q_item.kind == pef_pkg::KIND_BAD) begin
                  err_in = pef_pkg::ST_BADSYM;
               end else if (sp_ff == SPW'(D)) begin
                  err_in = pef_pkg::ST_OVF;
               end else begin
                  wr_en   = 1'b1;
                  wr_data = (q_item.kind == pef_pkg::KIND_NUM) ?
                            {1'b0, W'(q_item.digit)} : {1'b1, W'(q_item.code)};
                  sp_in   = sp_ff + SPW'(1);
                  st_in   = S_CHK;
               end
            end
         end
         S_CHK: st_in = (sp_ff < SPW'(3)) ? rest_state : S_R1;
         S_R1: begin
            if (rd_data_ff[W]) begin
               st_in = rest_state;
            end else begin
               b_in  = rd_data_ff[W-1:0];
               st_in = S_R2;
            end
         end
         S_R2: begin
            if (rd_data_ff[W]) begin
               st_in = rest_state;
            end else begin
               a_in  = rd_data_ff[W-1:0];
               st_in = S_R3;
            end
         end
         S_R3: begin
            if (!rd_data_ff[W]) begin
               st_in = rest_state;
            end else begin
               alu_start = 1'b1;
               st_in     = S_ALU;
            end
         end
         S_ALU: begin
            if (alu_done) begin
               if (alu_stat != pef_pkg::ST_OK) begin
                  err_in = alu_stat;
                  st_in  = rest_state;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = sp_m3[AW-1:0];
                  wr_data = {1'b0, alu_res};
                  sp_in   = sp_m2;
                  st_in   = S_CHK;
               end
            end
         end
         S_FIN: st_in = S_FRD;
         S_FRD: begin
            if (!ov_ff || !rsp_stall) begin
               ov_in = 1'b1;
               if (err_ff != pef_pkg::ST_OK) begin
                  ostat_in  = err_ff;
                  ovalue_in = '0;
               end else if (sp_ff == SPW'(1) && !rd_data_ff[W]) begin
                  ostat_in  = pef_pkg::ST_OK;
                  ovalue_in = 32'(signed'(rd_data_ff[W-1:0]));
               end else begin
                  ostat_in  = pef_pkg::ST_MALF;
                  ovalue_in = '0;
               end
               sp_in   = '0;
               err_in  = pef_pkg::ST_OK;
               last_in = 1'b0;
               st_in   = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_IDLE;
         sp_ff   <= '0;
         err_ff  <= pef_pkg::ST_OK;
         last_ff <= 1'b0;
         ov_ff   <= 1'b0;
      end else begin
         st_ff   <= st_in;
         sp_ff   <= sp_in;
         err_ff  <= err_in;
         last_ff <= last_in;
         ov_ff   <= ov_in;
      end
      a_ff      <= a_in;
      b_ff      <= b_in;
      ovalue_ff <= ovalue_in;
      ostat_ff  <= ostat_in;
   end

endmodule

// ----- rtl/prefix_expression_evaluator.sv -----
// Prefix expression evaluator: one ASCII character per item, one result per expression.
// The back end takes a character from the queue only while idle, pushes it and checks the stack;
// each reduction reads up to three stack entries and then waits for the arithmetic unit, which
// computes + and - directly and iterates for *, / and $. After the last character, S_FIN
// reads the bottom stack entry and S_FRD registers the result once any earlier one is taken.
// Synchronous reset empties queue and stack, drops any pending result; needs pef_pkg, modules.
module prefix_expression_evaluator #(
   parameter int STACK_DEPTH = 128,
   parameter int VALUE_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_symbol,
   input  logic               req_last_symbol,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_value,
   output logic [2:0]         rsp_status
);

   pef_pkg::item_type push_item, pop_item;
   logic q_push, q_full, q_valid, q_pop;

   // front end: classify each character as digit, operator or invalid
   pef_front u_front (
      .req_valid       (req_valid),
      .req_symbol      (req_symbol),
      .req_last_symbol (req_last_symbol),
      .q_full          (q_full),
      .req_stall       (req_stall),
      .q_push          (q_push),
      .q_item          (push_item)
   );

   // decouple classification from the stack sequencer
   pef_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop       (q_pop),
      .pop_item  (pop_item)
   );

   // back end: push, reduce through the arithmetic unit, and report
   pef_back #(
      .D (STACK_DEPTH),
      .W (VALUE_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (pop_item),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );

endmodule

// ----- rtl/pef_checker.sv -----
// Port-level checks for the prefix expression evaluator, bound to the top level.
// Depends on pef_pkg and prefix_expression_evaluator.
module pef_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_value,
   input logic [2:0]         rsp_status
);

   // an error result always carries a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != pef_pkg::ST_OK |-> rsp_value == 32'sd0)
      else $error("error result with non-zero value");

   // a stalled result holds its item
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status))
      else $error("stalled result changed");

   // reset drops any pending result
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // the queue is empty after reset, so input is taken
   a_ready: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("input stalled after reset");

endmodule

bind prefix_expression_evaluator pef_checker u_pef_checker (.*);
